// File: hw/rtl/accel_shake_and_face_detector_defines.svh
// ----------------------------------------------------------------------------
// Shake and face detector assertion macros
// Property shorthands sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_AND_FACE_DETECTOR_DEFINES_SVH
`define ACCEL_SHAKE_AND_FACE_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define ASFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/asfd_pkg.sv
// ----------------------------------------------------------------------------
// Shake and face detector package
// Event codes, sequencer states, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package asfd_pkg;

  typedef enum logic [1:0] {
    GESTURE_SHAKE     = 2'd0,
    GESTURE_FACE_DOWN = 2'd1,
    GESTURE_FACE_UP   = 2'd2
  } gesture_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_DECIDE
  } state_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int SHAKE_THR_W = 16;
  localparam int FACE_THR_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_THRESHOLD     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FACE_DOWN_THRESHOLD = 1'd1;

  localparam logic [SHAKE_THR_W-1:0] SHAKE_THR_RESET = 16'd1500;
  localparam logic [FACE_THR_W-1:0]  FACE_THR_RESET  = 15'd850;

  localparam logic [1:0] STEP_X    = 2'd0;
  localparam logic [1:0] STEP_Y    = 2'd1;
  localparam logic [1:0] STEP_Z    = 2'd2;
  localparam logic [1:0] STEP_LAST = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/asfd_if.sv
// ----------------------------------------------------------------------------
// Shake and face detector channels
// Sample channel and event channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface asfd_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface asfd_event_if import asfd_pkg::*;;
  logic     valid;
  logic     ready;
  gesture_t gesture;
  logic     last_event;

  modport source (output valid, output gesture, output last_event, input ready);
  modport sink (input valid, input gesture, input last_event, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/asfd_sumsq.sv
// ----------------------------------------------------------------------------
// Shake and face detector sum of squares
// One shared multiplier squares x, y and z in turn into an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module asfd_sumsq import asfd_pkg::*; #(
  parameter int N = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [N-1:0]  x,
  input  logic signed [N-1:0]  y,
  input  logic signed [N-1:0]  z,
  output logic                 done,
  output logic [2*N-1:0]       sum
);

  logic                busy;
  logic                pv;
  logic [1:0]          cnt;
  logic signed [N-1:0] x_r;
  logic signed [N-1:0] y_r;
  logic signed [N-1:0] z_r;
  logic signed [N-1:0] op;
  logic signed [2*N-1:0] sq;
  logic [2*N-1:0]      prod;
  logic [2*N-1:0]      acc;

  always_comb begin
    case (cnt)
      STEP_X:  op = x_r;
      STEP_Y:  op = y_r;
      default: op = z_r;
    endcase
  end

  assign sq = op * op;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      cnt  <= STEP_X;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pv   <= 1'b0;
        cnt  <= STEP_X;
      end else if (busy) begin
        pv  <= 1'b1;
        cnt <= cnt + 2'd1;
        if (cnt == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      z_r <= z;
      acc <= '0;
    end else if (busy) begin
      if (cnt != STEP_LAST) begin
        prod <= $unsigned(sq);
      end
      if (pv) begin
        acc <= acc + prod;
      end
    end
  end

  assign sum = acc;

endmodule

`default_nettype wire

// File: hw/rtl/asfd_isqrt.sv
// ----------------------------------------------------------------------------
// Shake and face detector integer square root
// Restoring digit-by-digit root, one result bit per cycle through one
// shared compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module asfd_isqrt #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*N-1:0] radicand,
  output logic           done,
  output logic [N-1:0]   root
);

  localparam int CW = $clog2(N + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [2*N-1:0] rad;
  logic [N-1:0]   rem;
  logic [N-1:0]   root_r;
  logic [N+1:0]   rem_sh;
  logic [N+1:0]   trial;
  logic [N+1:0]   diff;
  logic           fits;

  assign rem_sh = {rem, rad[2*N-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= radicand;
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      rad    <= rad << 2;
      rem    <= fits ? diff[N-1:0] : rem_sh[N-1:0];
      root_r <= {root_r[N-2:0], fits};
    end
  end

  assign root = root_r;

endmodule

`default_nettype wire

// File: hw/rtl/accel_shake_and_face_detector.sv
// ----------------------------------------------------------------------------
// Shake and face detector
// Magnitude of a three-axis sample by sum of squares and integer root; emits
// shake on a large magnitude jump and face-down / face-up on a z flip.
//
//   port        dir   width                  content
//   samples     in    3 x SAMPLE_BITS        accel_x, accel_y, accel_z (mg)
//   events      out   2 + 1                  gesture, last_event
//   cfg_*       in    1 index, 16 data       shake / face-down thresholds
//
// Each item passes through the shared squaring multiplier and its handoff,
// the one-bit-per-cycle root and its handoff, and then the decide step.
// samples.ready is high only when idle, so a new item is taken only once
// the previous one has been decided. Results sit in a two-entry output
// buffer, so a new item is taken while earlier events wait; the decide step
// holds until that buffer is empty. rst is synchronous and clears state and
// thresholds to defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_shake_and_face_detector_defines.svh"

module accel_shake_and_face_detector import asfd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  asfd_sample_if.sink            samples,
  asfd_event_if.source           events,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (SAMPLE_BITS > SHAKE_THR_W) ? SAMPLE_BITS : SHAKE_THR_W;
  localparam int ZW    = CMP_W + 2;

  state_t                  state;
  state_t                  state_next;
  logic                    accept;
  logic                    commit;
  logic                    pop;
  logic                    sq_done;
  logic [2*SAMPLE_BITS-1:0] sum;
  logic                    rt_done;
  logic [SAMPLE_BITS-1:0]  mag;
  logic [SAMPLE_BITS-1:0]  last_mag;
  logic [SAMPLE_BITS-1:0]  delta;
  logic                    down_flag;
  logic [SHAKE_THR_W-1:0]  shake_thr;
  logic [FACE_THR_W-1:0]   face_thr;
  logic [SAMPLE_BITS-1:0]  z_r;
  logic signed [ZW-1:0]    z_sum;
  logic                    down_test;
  logic                    shake;
  logic                    flip;
  gesture_t                face_g;
  logic [1:0]              ob_cnt;
  gesture_t                ob_g0;
  gesture_t                ob_g1;

  asfd_sumsq #(.N(SAMPLE_BITS)) u_sumsq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .x     (samples.accel_x),
    .y     (samples.accel_y),
    .z     (samples.accel_z),
    .done  (sq_done),
    .sum   (sum)
  );

  asfd_isqrt #(.N(SAMPLE_BITS)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_done),
    .radicand (sum),
    .done     (rt_done),
    .root     (mag)
  );

  assign delta     = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
  assign shake     = CMP_W'(delta) > CMP_W'(shake_thr);
  assign z_sum     = $signed({{(ZW-SAMPLE_BITS){z_r[SAMPLE_BITS-1]}}, z_r})
                   + $signed({{(ZW-FACE_THR_W){1'b0}}, face_thr});
  assign down_test = z_sum[ZW-1];
  assign flip      = down_test != down_flag;
  assign face_g    = down_test ? GESTURE_FACE_DOWN : GESTURE_FACE_UP;

  assign accept = samples.valid && samples.ready;
  assign pop    = events.valid && events.ready;

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    commit        = 1'b0;
    unique case (state)
      S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (sq_done) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rt_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (ob_cnt == 2'd0) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_mag  <= '0;
      down_flag <= 1'b0;
      shake_thr <= SHAKE_THR_RESET;
      face_thr  <= FACE_THR_RESET;
      ob_cnt    <= 2'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHAKE_THRESHOLD:     shake_thr <= cfg_data[SHAKE_THR_W-1:0];
          REG_FACE_DOWN_THRESHOLD: face_thr  <= cfg_data[FACE_THR_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        last_mag  <= mag;
        down_flag <= down_test;
        ob_cnt    <= {1'b0, shake} + {1'b0, flip};
      end else if (pop) begin
        ob_cnt <= ob_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_r <= samples.accel_z;
    end
    if (commit) begin
      ob_g0 <= shake ? GESTURE_SHAKE : face_g;
      ob_g1 <= face_g;
    end else if (pop) begin
      ob_g0 <= ob_g1;
    end
  end

  assign events.valid      = ob_cnt != 2'd0;
  assign events.gesture    = ob_g0;
  assign events.last_event = ob_cnt == 2'd1;

  `ASFD_ASSERT_NOW(a_buf_depth, 1'b1, ob_cnt != 2'd3, "output buffer overfilled")
  `ASFD_ASSERT_NEXT(a_accept_busy, accept, !samples.ready, "ready after accept")
  `ASFD_ASSERT_NOW(a_sq_in_state, sq_done, state == S_SQ, "square sum done out of step")
  `ASFD_ASSERT_NOW(a_rt_in_state, rt_done, state == S_ROOT, "root done out of step")
  `ASFD_ASSERT_NEXT(a_decide_commit, (state == S_DECIDE) && (ob_cnt == 2'd0),
                    state == S_IDLE, "decide did not commit")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Shake and face detector testbench
// Drives three-axis samples and threshold writes, predicts the shake and
// face-down / face-up events of each accepted sample and checks every event
// item in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import asfd_pkg::*;;

  localparam int SETTLE_CYCLES = 40;
  localparam int CHUNK_ITEMS   = 90;
  localparam int CHUNKS        = 7;

  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_DRAIN,
    ACT_PHASE
  } plan_kind_t;

  typedef struct {
    plan_kind_t               kind;
    logic signed [15:0]       x;
    logic signed [15:0]       y;
    logic signed [15:0]       z;
    logic [CFG_INDEX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]    data;
    int                       send_pct;
    int                       recv_pct;
  } plan_t;

  typedef struct packed {
    gesture_t gesture;
    logic     last_event;
  } gesture_rec_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  asfd_sample_if #(.SAMPLE_BITS(16)) smp ();
  asfd_event_if                      evt ();

  accel_shake_and_face_detector #(.SAMPLE_BITS(16)) u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp),
    .events    (evt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  plan_t        sample_plan[$];
  gesture_rec_t gesture_due[$];

  logic [SHAKE_THR_W-1:0] thr_shake     = SHAKE_THR_RESET;
  logic [FACE_THR_W-1:0]  thr_face      = FACE_THR_RESET;
  logic [15:0]            mag_prev      = '0;
  logic                   down_state    = 1'b0;

  logic [SHAKE_THR_W-1:0] gen_shake    = SHAKE_THR_RESET;
  logic [FACE_THR_W-1:0]  gen_face     = FACE_THR_RESET;
  logic [15:0]            gen_last_mag = '0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic holding       = 1'b0;
  int   hold_off      = 0;
  int   gesture_errors = 0;

  function automatic logic [15:0] root_floor(logic [33:0] n);
    logic [15:0] r;
    logic [15:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if (({18'd0, t} * {18'd0, t}) <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] magnitude_of(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
    longint ax;
    longint ay;
    longint az;
    longint sum;
    ax = x;
    ay = y;
    az = z;
    sum = ax * ax + ay * ay + az * az;
    return root_floor(sum[33:0]);
  endfunction

  function automatic void predict_gestures(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
    logic [15:0]  mag;
    logic [15:0]  jump;
    logic         down;
    gesture_rec_t rec;
    int           n;
    mag  = magnitude_of(x, y, z);
    jump = (mag >= mag_prev) ? mag - mag_prev : mag_prev - mag;
    n    = 0;
    mag_prev = mag;
    if (jump > thr_shake) begin
      rec.gesture    = GESTURE_SHAKE;
      rec.last_event = 1'b1;
      gesture_due.push_back(rec);
      n++;
    end
    down = longint'(z) < -longint'(thr_face);
    if (down != down_state) begin
      down_state = down;
      if (n > 0) gesture_due[gesture_due.size()-1].last_event = 1'b0;
      rec.gesture    = down ? GESTURE_FACE_DOWN : GESTURE_FACE_UP;
      rec.last_event = 1'b1;
      gesture_due.push_back(rec);
    end
  endfunction

  function automatic void note_error(string msg);
    if (gesture_errors < 10) $display("%s", msg);
    gesture_errors++;
  endfunction

  function automatic void add_sample(int x, int y, int z);
    plan_t p;
    p.kind = ACT_SAMPLE;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    sample_plan.push_back(p);
    gen_last_mag = magnitude_of(p.x, p.y, p.z);
  endfunction

  function automatic void add_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_t p;
    p.kind      = ACT_WRITE;
    p.reg_index = idx;
    p.data      = data;
    sample_plan.push_back(p);
    case (idx)
      REG_SHAKE_THRESHOLD:     gen_shake = data[SHAKE_THR_W-1:0];
      REG_FACE_DOWN_THRESHOLD: gen_face  = data[FACE_THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_drain();
    plan_t p;
    p.kind = ACT_DRAIN;
    sample_plan.push_back(p);
  endfunction

  function automatic void add_phase(int send_pct, int recv_pct);
    plan_t p;
    p.kind     = ACT_PHASE;
    p.send_pct = send_pct;
    p.recv_pct = recv_pct;
    sample_plan.push_back(p);
  endfunction

  function automatic void add_random_config();
    int          pick;
    logic [15:0] shake_val;
    logic [14:0] face_val;
    pick = $urandom_range(5);
    case (pick)
      0:       shake_val = 16'd0;
      1:       shake_val = 16'hFFFF;
      2:       shake_val = 16'($urandom_range(65535));
      default: shake_val = 16'($urandom_range(3000, 200));
    endcase
    pick = $urandom_range(5);
    case (pick)
      0:       face_val = 15'd0;
      1:       face_val = 15'h7FFF;
      2:       face_val = 15'($urandom_range(32767));
      default: face_val = 15'($urandom_range(1500, 300));
    endcase
    add_drain();
    add_write(REG_SHAKE_THRESHOLD, shake_val);
    add_write(REG_FACE_DOWN_THRESHOLD, {1'($urandom_range(1)), face_val});
  endfunction

  function automatic void add_random_sample();
    int style;
    int nx;
    int ny;
    int nz;
    int m;
    int d;
    style = $urandom_range(9);
    nx = int'($urandom_range(400)) - 200;
    ny = int'($urandom_range(400)) - 200;
    if (style < 4) begin
      add_sample($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    end else if (style < 8) begin
      nz = $urandom_range(1300, 700);
      if ($urandom_range(1)) nz = -nz;
      if ($urandom_range(9) < 3) nx = nx + int'($urandom_range(8000)) - 4000;
      add_sample(nx, ny, nz);
    end else if (style == 8) begin
      d  = int'($urandom_range(2)) - 1;
      nz = -(int'(gen_face) + d);
      if (nz < -32768) nz = -32768;
      add_sample(nx, ny, nz);
    end else begin
      d = int'(gen_shake) + int'($urandom_range(1));
      m = $urandom_range(1) ? int'(gen_last_mag) + d : int'(gen_last_mag) - d;
      if (m >= 0 && m <= 32767) add_sample(m, 0, 0);
      else add_sample($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1500000);
    $display("accel_shake_and_face_detector regression: fail");
    $finish;
  end

  always @(posedge clk) begin : driver
    plan_t p;
    logic  we;
    we = 1'b0;
    if (rst) begin
      smp.valid <= 1'b0;
      cfg_we    <= 1'b0;
      holding   = 1'b0;
      hold_off  = 0;
    end else begin
      if (holding && smp.ready) begin
        predict_gestures(smp.accel_x, smp.accel_y, smp.accel_z);
        holding = 1'b0;
      end
      if (hold_off > 0) begin
        hold_off--;
      end else if (!holding && sample_plan.size() > 0) begin
        p = sample_plan[0];
        case (p.kind)
          ACT_SAMPLE: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              smp.accel_x <= p.x;
              smp.accel_y <= p.y;
              smp.accel_z <= p.z;
              holding = 1'b1;
              sample_plan.delete(0);
            end
          end
          ACT_WRITE: begin
            we = 1'b1;
            cfg_index <= p.reg_index;
            cfg_data  <= p.data;
            case (p.reg_index)
              REG_SHAKE_THRESHOLD:     thr_shake = p.data[SHAKE_THR_W-1:0];
              REG_FACE_DOWN_THRESHOLD: thr_face  = p.data[FACE_THR_W-1:0];
              default: ;
            endcase
            sample_plan.delete(0);
          end
          ACT_DRAIN: begin
            if (gesture_due.size() == 0) begin
              hold_off = SETTLE_CYCLES;
              sample_plan.delete(0);
            end
          end
          default: begin
            send_idle_pct = p.send_pct;
            recv_idle_pct = p.recv_pct;
            sample_plan.delete(0);
          end
        endcase
      end
      smp.valid <= holding;
      cfg_we    <= we;
    end
  end

  always @(posedge clk) begin : monitor
    gesture_rec_t want;
    if (rst) begin
      evt.ready <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        if (gesture_due.size() == 0) begin
          note_error($sformatf("unexpected event: gesture %0d last %0b",
                               evt.gesture, evt.last_event));
        end else begin
          want = gesture_due.pop_front();
          if (evt.gesture !== want.gesture || evt.last_event !== want.last_event)
            note_error($sformatf("event mismatch: gesture exp %0d act %0d, last exp %0b act %0b",
                                 want.gesture, evt.gesture, want.last_event,
                                 evt.last_event));
        end
      end
      evt.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst         = 1'b1;
    smp.valid   = 1'b0;
    smp.accel_x = '0;
    smp.accel_y = '0;
    smp.accel_z = '0;
    evt.ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;

    add_phase(26, 76);
    add_sample(0, 0, 0);
    add_sample(0, 0, -32768);
    add_sample(32767, 32767, 32767);
    add_sample(-32768, -32768, -32768);
    add_sample(-32768, -32768, -32768);
    add_sample(0, 0, -851);
    add_sample(0, 0, -850);
    add_sample(0, 0, -851);
    add_sample(2351, 0, 0);
    add_sample(0, 0, -3852);
    add_drain();
    add_write(REG_SHAKE_THRESHOLD, 16'h0000);
    add_write(REG_FACE_DOWN_THRESHOLD, 16'h8000);
    add_sample(0, 0, -1);
    add_sample(0, 0, 0);
    add_sample(0, 0, 0);
    add_drain();
    add_write(REG_SHAKE_THRESHOLD, 16'hFFFF);
    add_write(REG_FACE_DOWN_THRESHOLD, 16'hFFFF);
    add_sample(0, 0, -32768);
    add_sample(0, 0, -32767);
    add_drain();
    add_write(REG_SHAKE_THRESHOLD, SHAKE_THR_RESET);
    add_write(REG_FACE_DOWN_THRESHOLD, {1'b0, FACE_THR_RESET});

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       add_phase(26, 76);
        1:       add_phase(76, 26);
        default: add_phase(0, 0);
      endcase
      for (int c = 0; c < CHUNKS; c++) begin
        if (c > 0) add_random_config();
        for (int i = 0; i < CHUNK_ITEMS; i++) add_random_sample();
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sample_plan.size() != 0 || holding || gesture_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (gesture_errors == 0 && gesture_due.size() == 0) begin
      $display("accel_shake_and_face_detector regression: pass");
    end else begin
      $display("accel_shake_and_face_detector regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
